@@ hdl/csdp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_pkg: shared types and constants of the chunked saturating dot product
// Field widths, register indexes, configuration and pipeline stage types.
// ----------------------------------------------------------------------------
package csdp_pkg;

   localparam int WEIGHT_W     = 16;
   localparam int ACT_W        = 16;
   localparam int BYTE_W       = 8;
   localparam int BIAS_W       = 32;
   localparam int PROD_W       = WEIGHT_W + ACT_W;
   localparam int SUM_W        = 32;
   localparam int SAT_COUNT_W  = 32;
   localparam int CFG_COUNT_W  = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHUNK_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INPUT_IS_BYTE = 2'd2;

   typedef struct packed {
      logic [CFG_COUNT_W-1:0] element_count;
      logic [CFG_COUNT_W-1:0] chunk_length;
      logic                   input_is_byte;
   } cfg_type;

   // Product stage: one term, with the control decided at acceptance
   typedef struct packed {
      logic              first;
      logic              clip;
      logic              last;
      logic [PROD_W-1:0] prod;
      logic [BIAS_W-1:0] bias;
   } stage_type;

endpackage : csdp_pkg
`default_nettype wire

@@ hdl/csdp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_req_if / csdp_rsp_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface csdp_req_if;
   import csdp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [WEIGHT_W-1:0] weight;
   logic signed [ACT_W-1:0]    activation;
   logic signed [BIAS_W-1:0]   bias;

   modport source (output valid, input ready, output weight, output activation,
                   output bias);
   modport sink   (input valid, output ready, input weight, input activation,
                   input bias);
endinterface : csdp_req_if

interface csdp_rsp_if;
   import csdp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SUM_W-1:0]   sum;
   logic [SAT_COUNT_W-1:0]    saturation_count;

   modport source (output valid, input ready, output sum, output saturation_count);
   modport sink   (input valid, output ready, input sum, input saturation_count);
endinterface : csdp_rsp_if
`default_nettype wire

@@ hdl/csdp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_front: request intake, term counters and product register
// Tracks term and chunk position, decides first/clip/last, registers w * a.
// ----------------------------------------------------------------------------
module csdp_front #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire csdp_pkg::cfg_type cfg,
   input  wire                  advance,
   csdp_req_if.sink             req,
   output logic                 s1_valid,
   output csdp_pkg::stage_type  s1
);
   import csdp_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > CFG_COUNT_W) ? COUNT_WIDTH : CFG_COUNT_W;

   logic [COUNT_WIDTH-1:0] term_ff, term_in;
   logic [COUNT_WIDTH-1:0] chunk_ff, chunk_in;
   logic [COUNT_WIDTH-1:0] next_term, next_chunk;
   logic                   accept, last, chunk_end;
   logic signed [ACT_W-1:0]  act_eff;
   logic signed [PROD_W-1:0] prod;
   logic                   s1_valid_ff;
   stage_type              s1_ff, s1_in;

   assign req.ready = advance;
   assign accept    = req.valid && advance;

   // Byte mode: sign-extend the low byte
   assign act_eff = cfg.input_is_byte
                    ? {{(ACT_W-BYTE_W){req.activation[BYTE_W-1]}},
                       req.activation[BYTE_W-1:0]}
                    : req.activation;
   assign prod = req.weight * act_eff;

   assign next_term  = term_ff + COUNT_WIDTH'(1);
   assign next_chunk = chunk_ff + COUNT_WIDTH'(1);
   // A counter one short of full also ends the output or the chunk
   assign last      = (CMP_W'(next_term) >= CMP_W'(cfg.element_count)) || (&next_term);
   assign chunk_end = (CMP_W'(next_chunk) >= CMP_W'(cfg.chunk_length)) || (&next_chunk);

   always_comb begin
      term_in  = last ? '0 : next_term;
      chunk_in = (last || chunk_end) ? '0 : next_chunk;
      s1_in.first = (term_ff == '0);
      s1_in.clip  = last || chunk_end;
      s1_in.last  = last;
      s1_in.prod  = prod;
      s1_in.bias  = req.bias;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff     <= '0;
         chunk_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            term_ff  <= term_in;
            chunk_ff <= chunk_in;
         end
         if (advance) begin
            s1_valid_ff <= req.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule : csdp_front
`default_nettype wire

@@ hdl/csdp_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_accum: accumulator, 32-bit clip, clip counter and result register
// Adds a product a cycle unless stalled, clips at chunk ends, outputs the sums.
// ----------------------------------------------------------------------------
module csdp_accum #(
   parameter int ACC_WIDTH = 48
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  s1_valid,
   input  wire csdp_pkg::stage_type s1,
   output logic                 advance,
   csdp_rsp_if.source           rsp
);
   import csdp_pkg::*;

   localparam int EXT_W = ACC_WIDTH - SUM_W;

   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [ACC_WIDTH-1:0]   base, total;
   logic [ACC_WIDTH-SUM_W:0] upper;
   logic                   pos_over, neg_over, clipped;
   logic [SAT_COUNT_W-1:0] clips_ff, clips_in;
   logic                   rsp_valid_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SAT_COUNT_W-1:0] count_ff;
   logic                   step;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign step    = advance && s1_valid;

   always_comb begin
      base  = s1.first ? {{EXT_W{s1.bias[BIAS_W-1]}}, s1.bias} : acc_ff;
      total = base + {{(ACC_WIDTH-PROD_W){s1.prod[PROD_W-1]}}, s1.prod};
      upper = total[ACC_WIDTH-1:SUM_W-1];
      pos_over = s1.clip && !total[ACC_WIDTH-1] && (|upper);
      neg_over = s1.clip && total[ACC_WIDTH-1] && !(&upper);
      clipped  = pos_over || neg_over;
      if (pos_over) begin
         acc_in = {{EXT_W{1'b0}}, 1'b0, {(SUM_W-1){1'b1}}};
      end else if (neg_over) begin
         acc_in = {{EXT_W{1'b1}}, 1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         acc_in = total;
      end
      clips_in = clips_ff + SAT_COUNT_W'(clipped);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         clips_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            acc_ff   <= acc_in;
            clips_ff <= clips_in;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid && s1.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && s1.last) begin
         sum_ff   <= acc_in[SUM_W-1:0];
         count_ff <= clips_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.sum              = sum_ff;
   assign rsp.saturation_count = count_ff;

endmodule : csdp_accum
`default_nettype wire

@@ hdl/chunked_saturating_dot_product.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_saturating_dot_product: int16 saturating multiply-accumulate
// Streams weight/activation pairs and returns one clipped 32-bit affine sum.
// ----------------------------------------------------------------------------
// Each request carries one weight/activation pair (and the bias, used only on
// the first term of an output). The block takes one request every cycle while
// no result is held untaken. The first stage registers the 16x16 product along
// with the term and chunk decisions, the second adds it into the ACC_WIDTH-bit
// accumulator and clips to signed 32 bits at chunk ends and at the last term.
// The accumulate-and-clip loop sets the rate of one request per cycle. A result
// appears after element_count terms (zero counts as one) and carries the sum and
// a wrapping count, kept since reset, of clips that changed the value. The
// result register refills in the same cycle its result is taken, so requests
// keep flowing; ready only drops while a result is held and not taken. Write
// the CSR port only while no output is in flight.
module chunked_saturating_dot_product #(
   parameter int COUNT_WIDTH = 16,
   parameter int ACC_WIDTH   = 48
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire [csdp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [csdp_pkg::CSR_DATA_W-1:0]    csr_data,
   csdp_req_if.sink                          req,
   csdp_rsp_if.source                        rsp
);
   import csdp_pkg::*;

   cfg_type   cfg_ff;
   logic      advance;
   logic      s1_valid;
   stage_type s1;

   // Configuration registers; writes to unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.element_count <= CFG_COUNT_W'(1);
         cfg_ff.chunk_length  <= CFG_COUNT_W'(1);
         cfg_ff.input_is_byte <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ELEMENT_COUNT: begin
               cfg_ff.element_count <= csr_data[CFG_COUNT_W-1:0];
            end
            REG_CHUNK_LENGTH: begin
               cfg_ff.chunk_length <= csr_data[CFG_COUNT_W-1:0];
            end
            REG_INPUT_IS_BYTE: begin
               cfg_ff.input_is_byte <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Count terms and chunks, register the product
   csdp_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .advance  (advance),
      .req      (req),
      .s1_valid (s1_valid),
      .s1       (s1)
   );

   // Accumulate, clip, hold the result until taken
   csdp_accum #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .advance  (advance),
      .rsp      (rsp)
   );

endmodule : chunked_saturating_dot_product
`default_nettype wire

@@ hdl/csdp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_checker: port-level checks of the dot product
// Watches reset, flow control and result timing on the top-level ports.
// ----------------------------------------------------------------------------
module csdp_checker (
   input  wire          clock,
   input  wire          reset,
   csdp_req_if.sink     req,
   csdp_rsp_if.source   rsp
);
   import csdp_pkg::*;

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("result valid after reset");

   // With no result pending the block never stalls requests
   assert property (@(posedge clock) disable iff (reset) !rsp.valid |-> req.ready)
      else $error("request stalled with empty result register");

   // A new result follows an accepted request through the product and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(req.valid && req.ready, 2))
      else $error("result without matching request");

   // A held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.sum)
                                     && $stable(rsp.saturation_count)))
      else $error("stalled result changed");

endmodule : csdp_checker

bind chunked_saturating_dot_product csdp_checker u_csdp_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);
`default_nettype wire
